/* sv/swept_box_impact_time_assert.svh */
// assertion macros for the swept box impact time block
`ifndef SWEPT_BOX_IMPACT_TIME_ASSERT_SVH
`define SWEPT_BOX_IMPACT_TIME_ASSERT_SVH

// checked outside reset
`define SBIT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define SBIT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/sbit_pkg.sv */
// types and constants shared by the swept box impact time block
package sbit_pkg;

   localparam int COORD_W = 24;
   localparam int FRAC_W  = 16;
   localparam int SIZE_W  = COORD_W - 1;
   localparam int EDGE_W  = COORD_W + 1;
   localparam int DIST_W  = COORD_W + 2;
   localparam int MAG_W   = COORD_W + 1;
   localparam int DEN_W   = COORD_W;
   localparam int NUM_W   = MAG_W + FRAC_W;
   localparam int QUO_W   = NUM_W + 2;
   localparam int DIV_LAT = NUM_W + 2;
   localparam int THR_W   = 8;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

   localparam logic signed [QUO_W-1:0] TIME_MIN = {1'b1, {(QUO_W-1){1'b0}}};
   localparam logic signed [QUO_W-1:0] TIME_MAX = {1'b0, {(QUO_W-1){1'b1}}};
   localparam logic signed [QUO_W-1:0] TIME_ONE = QUO_W'(1) << FRAC_W;

   typedef struct packed {
      logic signed [COORD_W-1:0] body_left;
      logic signed [COORD_W-1:0] body_top;
      logic        [SIZE_W-1:0]  body_width;
      logic        [SIZE_W-1:0]  body_height;
      logic signed [COORD_W-1:0] plat_left;
      logic signed [COORD_W-1:0] plat_top;
      logic        [SIZE_W-1:0]  plat_width;
      logic        [SIZE_W-1:0]  plat_height;
      logic signed [COORD_W-1:0] disp_x;
      logic signed [COORD_W-1:0] disp_y;
   } req_beat_type;

   typedef struct packed {
      logic              hit;
      logic [FRAC_W-1:0] impact_time;
      logic              contact_axis;
   } rsp_beat_type;

endpackage

/* sv/swept_box_impact_time.sv */
// swept box impact time: hit, first contact time and contact axis of a moving box
// pipeline: 3 front stages (capture, edges, distances), the bit-per-stage dividers,
//    then the selection and output registers
// throughput: one beat per cycle while the skid entry is empty; a two-entry output
//    buffer absorbs one beat while the consumer stalls, and req_ready drops until it drains
// reset: synchronous, clears all valid bits and sets still_threshold to 1
module swept_box_impact_time (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  sbit_pkg::req_beat_type       req_beat,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output sbit_pkg::rsp_beat_type       rsp_beat,
   input  logic                         csr_wr_en,
   input  logic [sbit_pkg::THR_W-1:0]   csr_wr_data
);

   localparam int W  = sbit_pkg::COORD_W;
   localparam int EW = sbit_pkg::EDGE_W;
   localparam int DW = sbit_pkg::DIST_W;
   localparam int AW = sbit_pkg::DEN_W;
   localparam int QW = sbit_pkg::QUO_W;
   localparam int L  = sbit_pkg::DIV_LAT;

   typedef struct packed {
      logic signed [EW-1:0] bl;
      logic signed [EW-1:0] br;
      logic signed [EW-1:0] bt;
      logic signed [EW-1:0] bb;
      logic signed [EW-1:0] pl;
      logic signed [EW-1:0] pr;
      logic signed [EW-1:0] pt;
      logic signed [EW-1:0] pb;
      logic                 nx;
      logic                 ny;
      logic [AW-1:0]        adx;
      logic [AW-1:0]        ady;
   } edge_type;

   typedef struct packed {
      logic                 sx;
      logic                 sy;
      logic                 ovx;
      logic                 ovy;
      logic                 r5x;
      logic                 r5y;
      logic signed [DW-1:0] xo;
      logic signed [DW-1:0] yo;
   } side_type;

   typedef struct packed {
      logic                 sx;
      logic                 sy;
      logic                 ovx;
      logic                 ovy;
      logic                 r5x;
      logic                 r5y;
      logic                 xlt;
      logic                 gtx;
      logic                 gty;
      logic signed [QW-1:0] first;
      logic signed [QW-1:0] last;
   } pick_type;

   logic [sbit_pkg::THR_W-1:0] thr_ff;
   logic en;

   sbit_pkg::req_beat_type s1_ff;
   logic s1_valid_ff;
   edge_type e_in, e_ff;
   logic e_valid_ff;
   side_type sd_in, sd_ff;
   logic signed [DW-1:0] enx_in, exx_in, eny_in, exy_in;
   logic signed [DW-1:0] enx_ff, exx_ff, eny_ff, exy_ff;
   logic sd_valid_ff;
   logic [AW-1:0] e_adx_q, e_ady_q;

   side_type line_ff [L];
   logic     line_valid_ff [L];

   logic signed [QW-1:0] entx, extx, enty, exty;
   pick_type pk_in, pk_ff;
   logic pk_valid_ff;

   sbit_pkg::rsp_beat_type res_in, out_ff, skid_ff;
   logic out_valid_ff, skid_valid_ff;
   logic take_in;
   logic ok_in;
   logic [AW+2:0] fx_in, fy_in, qx_in, qy_in;

   assign en        = !skid_valid_ff;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= sbit_pkg::THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // stage 1: capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= req_beat;
      end
   end

   // stage 2: edges and magnitudes
   always_comb begin
      e_in.bl  = EW'(s1_ff.body_left);
      e_in.bt  = EW'(s1_ff.body_top);
      e_in.pl  = EW'(s1_ff.plat_left);
      e_in.pt  = EW'(s1_ff.plat_top);
      e_in.br  = EW'(s1_ff.body_left) + $signed({2'b00, s1_ff.body_width});
      e_in.bb  = EW'(s1_ff.body_top) + $signed({2'b00, s1_ff.body_height});
      e_in.pr  = EW'(s1_ff.plat_left) + $signed({2'b00, s1_ff.plat_width});
      e_in.pb  = EW'(s1_ff.plat_top) + $signed({2'b00, s1_ff.plat_height});
      e_in.nx  = s1_ff.disp_x[W-1];
      e_in.ny  = s1_ff.disp_y[W-1];
      e_in.adx = s1_ff.disp_x[W-1] ? AW'(-s1_ff.disp_x) : AW'(s1_ff.disp_x);
      e_in.ady = s1_ff.disp_y[W-1] ? AW'(-s1_ff.disp_y) : AW'(s1_ff.disp_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= s1_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         e_ff <= e_in;
      end
   end

   // stage 3: distances, still flags, overlaps
   always_comb begin
      logic signed [DW-1:0] ax, bx, ay, by;
      logic [AW+2:0] thr_x;
      ax = DW'(e_ff.pr) - DW'(e_ff.bl);
      bx = DW'(e_ff.br) - DW'(e_ff.pl);
      ay = DW'(e_ff.pb) - DW'(e_ff.bt);
      by = DW'(e_ff.bb) - DW'(e_ff.pt);
      thr_x = (AW+3)'(thr_ff);
      enx_in = e_ff.nx ? (DW'(e_ff.bl) - DW'(e_ff.pr)) : (DW'(e_ff.pl) - DW'(e_ff.br));
      exx_in = e_ff.nx ? bx : ax;
      eny_in = e_ff.ny ? (DW'(e_ff.bt) - DW'(e_ff.pb)) : (DW'(e_ff.pt) - DW'(e_ff.bb));
      exy_in = e_ff.ny ? by : ay;
      sd_in.sx  = (e_ff.adx == '0) || ((AW+3)'(e_ff.adx) < thr_x);
      sd_in.sy  = (e_ff.ady == '0) || ((AW+3)'(e_ff.ady) < thr_x);
      sd_in.ovx = (e_ff.bl < e_ff.pr) && (e_ff.pl < e_ff.br);
      sd_in.ovy = (e_ff.bt < e_ff.pb) && (e_ff.pt < e_ff.bb);
      fx_in = ((AW+3)'(e_ff.adx) << 2);
      fy_in = ((AW+3)'(e_ff.ady) << 2);
      qx_in = fx_in + (AW+3)'(e_ff.adx);
      qy_in = fy_in + (AW+3)'(e_ff.ady);
      sd_in.r5y = qy_in > fx_in;
      sd_in.r5x = qx_in > fy_in;
      sd_in.xo  = (ax < bx) ? ax : bx;
      sd_in.yo  = (ay < by) ? ay : by;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sd_valid_ff <= 1'b0;
      end else if (en) begin
         sd_valid_ff <= e_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff  <= sd_in;
         enx_ff <= enx_in;
         exx_ff <= exx_in;
         eny_ff <= eny_in;
         exy_ff <= exy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_adx_q <= e_ff.adx;
         e_ady_q <= e_ff.ady;
      end
   end

   sbit_div u_div_enx (.clock(clock), .en(en), .num(enx_ff), .den(e_adx_q), .quo(entx));
   sbit_div u_div_exx (.clock(clock), .en(en), .num(exx_ff), .den(e_adx_q), .quo(extx));
   sbit_div u_div_eny (.clock(clock), .en(en), .num(eny_ff), .den(e_ady_q), .quo(enty));
   sbit_div u_div_exy (.clock(clock), .en(en), .num(exy_ff), .den(e_ady_q), .quo(exty));

   // sideband delay matched to the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < L; k++) begin
            line_valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         line_valid_ff[0] <= sd_valid_ff;
         for (int k = 1; k < L; k++) begin
            line_valid_ff[k] <= line_valid_ff[k-1];
         end
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= sd_ff;
         for (int k = 1; k < L; k++) begin
            line_ff[k] <= line_ff[k-1];
         end
      end
   end

   // selection stage: latest entry, earliest exit
   always_comb begin
      logic signed [QW-1:0] ex, ey, xx, xy;
      ex = line_ff[L-1].sx ? sbit_pkg::TIME_MIN : entx;
      xx = line_ff[L-1].sx ? sbit_pkg::TIME_MAX : extx;
      ey = line_ff[L-1].sy ? sbit_pkg::TIME_MIN : enty;
      xy = line_ff[L-1].sy ? sbit_pkg::TIME_MAX : exty;
      pk_in.sx    = line_ff[L-1].sx;
      pk_in.sy    = line_ff[L-1].sy;
      pk_in.ovx   = line_ff[L-1].ovx;
      pk_in.ovy   = line_ff[L-1].ovy;
      pk_in.r5x   = line_ff[L-1].r5x;
      pk_in.r5y   = line_ff[L-1].r5y;
      pk_in.xlt   = line_ff[L-1].xo < line_ff[L-1].yo;
      pk_in.gtx   = ex > ey;
      pk_in.gty   = ey > ex;
      pk_in.first = (ex > ey) ? ex : ey;
      pk_in.last  = (xx < xy) ? xx : xy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pk_valid_ff <= 1'b0;
      end else if (en) begin
         pk_valid_ff <= line_valid_ff[L-1];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         pk_ff <= pk_in;
      end
   end

   // decision
   always_comb begin
      res_in = '0;
      ok_in  = 1'b0;
      if (pk_ff.sx && pk_ff.sy) begin
         if (pk_ff.ovx && pk_ff.ovy) begin
            res_in.hit          = 1'b1;
            res_in.contact_axis = !pk_ff.xlt;
         end
      end else begin
         ok_in = (!pk_ff.sx || pk_ff.ovx) && (!pk_ff.sy || pk_ff.ovy) &&
                 !(pk_ff.first > pk_ff.last) && (pk_ff.first < sbit_pkg::TIME_ONE) &&
                 (pk_ff.last > 0);
         if (ok_in) begin
            res_in.hit         = 1'b1;
            res_in.impact_time = pk_ff.first[QW-1] ? '0 : pk_ff.first[sbit_pkg::FRAC_W-1:0];
            if (pk_ff.gtx) begin
               res_in.contact_axis = 1'b0;
            end else if (pk_ff.gty) begin
               res_in.contact_axis = 1'b1;
            end else if (pk_ff.r5y) begin
               res_in.contact_axis = 1'b1;
            end else if (pk_ff.r5x) begin
               res_in.contact_axis = 1'b0;
            end else begin
               res_in.contact_axis = !pk_ff.xlt;
            end
         end
      end
   end

   // output register with skid entry
   assign take_in = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (pk_valid_ff) begin
         if (take_in) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            out_ff <= skid_ff;
         end
      end else if (pk_valid_ff) begin
         if (take_in) begin
            out_ff <= res_in;
         end else begin
            skid_ff <= res_in;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_beat  = out_ff;

endmodule

/* sv/sbit_div.sv */
// pipelined floor division of a signed distance scaled by 2^frac by a positive magnitude
module sbit_div (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [sbit_pkg::DIST_W-1:0] num,
   input  logic        [sbit_pkg::DEN_W-1:0]  den,
   output logic signed [sbit_pkg::QUO_W-1:0]  quo
);

   localparam int NW = sbit_pkg::NUM_W;
   localparam int AW = sbit_pkg::DEN_W;

   logic [AW-1:0] rem_ff [NW+1];
   logic [NW-1:0] nq_ff  [NW+1];
   logic [AW-1:0] den_ff [NW];
   logic          neg_ff [NW+1];

   logic [sbit_pkg::DIST_W-1:0] abs_in;
   logic signed [sbit_pkg::QUO_W-1:0] qx_in;
   logic signed [sbit_pkg::QUO_W-1:0] quo_in;
   logic signed [sbit_pkg::QUO_W-1:0] quo_ff;

   assign abs_in = num[sbit_pkg::DIST_W-1] ? sbit_pkg::DIST_W'(-num)
                                           : sbit_pkg::DIST_W'(num);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= '0;
         nq_ff[0]  <= {abs_in[sbit_pkg::MAG_W-1:0], {sbit_pkg::FRAC_W{1'b0}}};
         den_ff[0] <= den;
         neg_ff[0] <= num[sbit_pkg::DIST_W-1];
      end
   end

   for (genvar k = 0; k < NW; k++) begin : g_step
      logic [AW:0]   t_in;
      logic [AW:0]   diff_in;
      logic          ge_in;
      assign t_in    = {rem_ff[k], nq_ff[k][NW-1]};
      assign ge_in   = t_in >= {1'b0, den_ff[k]};
      assign diff_in = t_in - {1'b0, den_ff[k]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge_in ? diff_in[AW-1:0] : t_in[AW-1:0];
            nq_ff[k+1]  <= {nq_ff[k][NW-2:0], ge_in};
            neg_ff[k+1] <= neg_ff[k];
         end
      end
      if (k < NW - 1) begin : g_den
         always_ff @(posedge clock) begin
            if (en) begin
               den_ff[k+1] <= den_ff[k];
            end
         end
      end
   end

   assign qx_in  = $signed({2'b00, nq_ff[NW]});
   assign quo_in = neg_ff[NW] ? -(qx_in + sbit_pkg::QUO_W'(rem_ff[NW] != '0)) : qx_in;

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

/* sv/sbit_check.sv */
// port-level checks for the swept box impact time block, bound to the top level
`include "swept_box_impact_time_assert.svh"

module sbit_check (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input sbit_pkg::rsp_beat_type rsp_beat
);

   `SBIT_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp valid after reset")
   `SBIT_ASSERT(a_miss_zero, clock, reset, rsp_valid && !rsp_beat.hit |-> rsp_beat.impact_time == '0 && !rsp_beat.contact_axis, "miss beat carries nonzero fields")
   `SBIT_ASSERT(a_stall_full, clock, reset, !req_ready |-> rsp_valid, "req stalled with no rsp pending")
   `SBIT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_beat), "stalled rsp beat changed")

endmodule

bind swept_box_impact_time sbit_check u_sbit_check (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_beat(rsp_beat)
);
